// ----- sv/rational_arithmetic_unit_assert.svh -----
// assertion helpers used by rational_arithmetic_unit.sv
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rau assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rau assertion failed");

`endif

// ----- sv/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, codes and helpers of the rational arithmetic unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    localparam int unsigned WordW = 64;

    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_SUB = 4'd1;
    localparam logic [3:0] CMD_MUL = 4'd2;
    localparam logic [3:0] CMD_DIV = 4'd3;
    localparam logic [3:0] CMD_LT  = 4'd4;
    localparam logic [3:0] CMD_GT  = 4'd5;
    localparam logic [3:0] CMD_LE  = 4'd6;
    localparam logic [3:0] CMD_GE  = 4'd7;
    localparam logic [3:0] CMD_EQ  = 4'd8;
    localparam logic [3:0] CMD_NE  = 4'd9;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_GCDL  = 11'b00000000010,
        S_GCDW  = 11'b00000000100,
        S_DIV1L = 11'b00000001000,
        S_DIV1W = 11'b00000010000,
        S_DIV2L = 11'b00000100000,
        S_DIV2W = 11'b00001000000,
        S_MUL1  = 11'b00010000000,
        S_MUL2  = 11'b00100000000,
        S_MUL3  = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } state_t;

    function automatic logic [WordW-1:0] mag64(input logic [WordW-1:0] v);
        return v[WordW-1] ? ({WordW{1'b0}} - v) : v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// rational add, sub, mul, div and compare over 32-bit fractions
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one command with fractions a and b; m_ channel returns
//   numerator, denominator, compare flag and status, one result per command.
//   one command is worked on at a time; s_tready is high only while idle.
//   sequence, from input transfer to m_tvalid:
//     add/sub : binary gcd of the 32-bit denominator magnitudes, two
//               divider passes, then the multiplier steps
//     mul/div : multiplier steps, then binary gcd of the 64-bit
//               products and two divider passes
//     compare : multiplier steps only
//     zero denominator, divide by zero, unused code: straight to result
//   one 33x33 multiplier is reused for every product.
//   the result waits in an output register while m_tready is low, and the
//   next command is accepted meanwhile; its result is held back until the
//   register frees.
//   synchronous active-low reset empties the output and returns to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rational_arithmetic_unit_assert.svh"

module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[3:0], a_num[35:4], a_den[67:36], b_num[99:68], b_den[131:100]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num[63:0], res_den[127:64], cmp_true[128], status[130:129]
    output logic [135:0] m_tdata
);

    state_t state_reg, state_next;

    logic [3:0]  cmd_reg;
    logic [31:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic        zden_reg, divz_reg;
    logic [63:0] p_reg, q_reg, l_reg, qa_reg, qb_reg;

    logic        out_valid_reg;
    logic [63:0] out_num_reg, out_den_reg;
    logic        out_cmp_reg;
    logic [1:0]  out_st_reg;

    logic        accept;
    logic        is_arith, is_cmp;
    logic [31:0] ma, mb;

    logic               gcd_start, gcd_done;
    logic [63:0]        gcd_a, gcd_b, gcd_result;
    logic               div_start, div_done;
    logic [63:0]        div_dividend, div_quo;

    logic signed [32:0] mul_op1, mul_op2;
    logic signed [65:0] mul_prod;

    logic [63:0] fin_num, fin_den, sum;
    logic        fin_cmp, ovf, lt_raw, gt_raw, eq, flip, lt, gt;
    logic [1:0]  fin_st;
    logic        out_free;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign is_arith  = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB);
    assign is_cmp    = (cmd_reg >= CMD_LT) && (cmd_reg <= CMD_NE);
    assign ma        = ad_reg[31] ? (32'd0 - ad_reg) : ad_reg;
    assign mb        = bd_reg[31] ? (32'd0 - bd_reg) : bd_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // shared units
    assign gcd_start = (state_reg == S_GCDL);
    assign gcd_a     = is_arith ? {32'd0, ma} : mag64(p_reg);
    assign gcd_b     = is_arith ? {32'd0, mb} : mag64(q_reg);

    rau_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .a_in    (gcd_a),
        .b_in    (gcd_b),
        .done    (gcd_done),
        .result  (gcd_result)
    );

    assign div_start = (state_reg == S_DIV1L) || (state_reg == S_DIV2L);
    always_comb begin
        if (state_reg == S_DIV1L) begin
            div_dividend = is_arith ? {32'd0, mb} : mag64(p_reg);
        end else begin
            div_dividend = is_arith ? {32'd0, ma} : mag64(q_reg);
        end
    end

    rau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_result),
        .done     (div_done),
        .quotient (div_quo)
    );

    // multiplier operand select
    always_comb begin
        mul_op1 = '0;
        mul_op2 = '0;
        unique case (state_reg)
            S_MUL1: begin
                if (is_arith) begin
                    mul_op1 = ad_reg[31] ? (33'sd0 - $signed({an_reg[31], an_reg}))
                                         : $signed({an_reg[31], an_reg});
                    mul_op2 = $signed({1'b0, qa_reg[31:0]});
                end else begin
                    mul_op1 = $signed({an_reg[31], an_reg});
                    mul_op2 = (cmd_reg == CMD_MUL) ? $signed({bn_reg[31], bn_reg})
                                                   : $signed({bd_reg[31], bd_reg});
                end
            end
            S_MUL2: begin
                if (is_arith) begin
                    // subtract folds into the sign of the second term
                    mul_op1 = (bd_reg[31] ^ (cmd_reg == CMD_SUB))
                            ? (33'sd0 - $signed({bn_reg[31], bn_reg}))
                            : $signed({bn_reg[31], bn_reg});
                    mul_op2 = $signed({1'b0, qb_reg[31:0]});
                end else begin
                    mul_op1 = $signed({ad_reg[31], ad_reg});
                    mul_op2 = (cmd_reg == CMD_MUL) ? $signed({bd_reg[31], bd_reg})
                                                   : $signed({bn_reg[31], bn_reg});
                end
            end
            S_MUL3: begin
                mul_op1 = $signed({1'b0, ma});
                mul_op2 = $signed({1'b0, qa_reg[31:0]});
            end
            default: begin
                mul_op1 = '0;
                mul_op2 = '0;
            end
        endcase
    end

    assign mul_prod = mul_op1 * mul_op2;

    // final result
    always_comb begin
        sum    = p_reg + q_reg;
        ovf    = (p_reg[63] == q_reg[63]) && (sum[63] != p_reg[63]);
        lt_raw = $signed(p_reg) < $signed(q_reg);
        gt_raw = $signed(p_reg) > $signed(q_reg);
        eq     = (p_reg == q_reg);
        flip   = ad_reg[31] ^ bd_reg[31];
        lt     = flip ? gt_raw : lt_raw;
        gt     = flip ? lt_raw : gt_raw;

        fin_num = '0;
        fin_den = '0;
        fin_cmp = 1'b0;
        fin_st  = ST_OK;
        if (zden_reg) begin
            fin_st = ST_ZERO_DEN;
        end else if (divz_reg) begin
            fin_st = ST_DIV_ZERO;
        end else begin
            case (cmd_reg) inside
                CMD_ADD, CMD_SUB: begin
                    if (ovf) begin
                        fin_st = ST_OVERFLOW;
                    end else begin
                        fin_num = sum;
                        fin_den = l_reg;
                    end
                end
                CMD_MUL, CMD_DIV: begin
                    fin_num = p_reg[63] ? (64'd0 - qa_reg) : qa_reg;
                    fin_den = q_reg[63] ? (64'd0 - qb_reg) : qb_reg;
                end
                CMD_LT: fin_cmp = lt;
                CMD_GT: fin_cmp = gt;
                CMD_LE: fin_cmp = lt || eq;
                CMD_GE: fin_cmp = gt || eq;
                CMD_EQ: fin_cmp = eq;
                CMD_NE: fin_cmp = !eq;
                default: fin_cmp = 1'b0;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if ((s_tdata[67:36] == '0) || (s_tdata[131:100] == '0)
                        || ((s_tdata[3:0] == CMD_DIV) && (s_tdata[99:68] == '0))
                        || (s_tdata[3:0] > CMD_NE)) begin
                        state_next = S_FIN;
                    end else if ((s_tdata[3:0] == CMD_ADD) || (s_tdata[3:0] == CMD_SUB)) begin
                        state_next = S_GCDL;
                    end else begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_GCDL:  state_next = S_GCDW;
            S_GCDW:  if (gcd_done) state_next = S_DIV1L;
            S_DIV1L: state_next = S_DIV1W;
            S_DIV1W: if (div_done) state_next = S_DIV2L;
            S_DIV2L: state_next = S_DIV2W;
            S_DIV2W: begin
                if (div_done) state_next = is_arith ? S_MUL1 : S_FIN;
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2: begin
                if (is_arith) begin
                    state_next = S_MUL3;
                end else if (is_cmp) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_GCDL;
                end
            end
            S_MUL3:  state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= (state_reg == S_FIN && out_free) || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_tdata[3:0];
            an_reg   <= s_tdata[35:4];
            ad_reg   <= s_tdata[67:36];
            bn_reg   <= s_tdata[99:68];
            bd_reg   <= s_tdata[131:100];
            zden_reg <= (s_tdata[67:36] == '0) || (s_tdata[131:100] == '0);
            divz_reg <= (s_tdata[3:0] == CMD_DIV) && (s_tdata[99:68] == '0);
        end
        if (state_reg == S_MUL1) p_reg <= mul_prod[63:0];
        if (state_reg == S_MUL2) q_reg <= mul_prod[63:0];
        if (state_reg == S_MUL3) l_reg <= mul_prod[63:0];
        if (state_reg == S_DIV1W && div_done) qa_reg <= div_quo;
        if (state_reg == S_DIV2W && div_done) qb_reg <= div_quo;
        if (state_reg == S_FIN && out_free) begin
            out_num_reg <= fin_num;
            out_den_reg <= fin_den;
            out_cmp_reg <= fin_cmp;
            out_st_reg  <= fin_st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_st_reg, out_cmp_reg, out_den_reg, out_num_reg};

    `RAU_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, accept, !s_tready)
    `RAU_ASSERT(a_zero_den_clean, aclk, aresetn, m_tvalid && (m_tdata[130:129] == ST_ZERO_DEN), m_tdata[128:0] == '0)
    `RAU_ASSERT(a_gcd_nonzero, aclk, aresetn, gcd_done, gcd_result != '0)

endmodule

`default_nettype wire

// ----- sv/rau_gcd.sv -----
// ----------------------------------------------------------------------------
// rau_gcd
// binary gcd engine, one shift or subtract per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_gcd
    import rau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WordW-1:0] a_in,
    input  logic [WordW-1:0] b_in,
    output logic             done,
    output logic [WordW-1:0] result
);

    logic [WordW-1:0] x_reg;
    logic [WordW-1:0] y_reg;
    logic [5:0]       k_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WordW-1:0] res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= a_in;
                y_reg    <= b_in;
                k_reg    <= 6'd0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (x_reg == '0 || y_reg == '0) begin
                    res_reg  <= (x_reg | y_reg) << k_reg;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    // common factor of two
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 6'd1;
                end else if (!x_reg[0]) begin
                    x_reg <= x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_reg <= y_reg >> 1;
                end else if (x_reg >= y_reg) begin
                    x_reg <= x_reg - y_reg;
                end else begin
                    y_reg <= y_reg - x_reg;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ----- sv/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_div
    import rau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WordW-1:0] dividend,
    input  logic [WordW-1:0] divisor,
    output logic             done,
    output logic [WordW-1:0] quotient
);

    logic [WordW-1:0] rem_reg;
    logic [WordW-1:0] quo_reg;
    logic [WordW-1:0] dvs_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WordW:0]   shifted;
    logic [WordW:0]   trial;
    logic             fits;
    logic [WordW-1:0] rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[WordW-1]};
        trial    = shifted - {1'b0, dvs_reg};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? trial[WordW-1:0] : shifted[WordW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= 6'd0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[WordW-2:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
